// ===== hw/rtl/icymd_pkg.sv =====
// Shared types and constants for the ICY metadata demultiplexer.
// Used by icymd_core, icymd_out and icy_metadata_demux; depends on nothing.

package icymd_pkg;

   localparam int unsigned INTERVAL_W = 24;
   localparam int unsigned META_W     = 12;
   localparam int unsigned BYTE_W     = 8;
   // A length byte counts units of sixteen metadata bytes.
   localparam int unsigned UNIT_SHIFT = 4;

   typedef enum logic [1:0] {
      PH_AUDIO  = 2'd0,
      PH_LENGTH = 2'd1,
      PH_META   = 2'd2
   } phase_type;

   typedef enum logic {
      OP_BYTE    = 1'b0,
      OP_RESTART = 1'b1
   } op_type;

   typedef enum logic {
      KIND_AUDIO = 1'b0,
      KIND_META  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic              block_end;
   } result_type;

endpackage

// ===== hw/rtl/icy_metadata_demux.sv =====
// Top level of the ICY metadata demultiplexer.
// Depends on icymd_pkg, icymd_core and icymd_out.
//
//   channel   direction  accepted when               carries
//   req_*     in         req_tvalid & req_tready     tuser operation, tdata stream_byte
//   rsp_*     out        rsp_tvalid & rsp_tready     tuser kind, tdata data, tlast block_end
//   csr_*     in         csr_valid & csr_ready       metadata_interval
//
// One item is accepted per cycle unless the rsp side stalls; it is held in the input register
// while the phase and counter logic classifies it, and its result lands in the output register.
// rsp_tvalid is the output register's valid flag. Length bytes and restarts give
// no result. A stalled rsp side holds the output register and, through it, the input
// register. Reset is synchronous and clears the interval, phase and counters.

module icy_metadata_demux (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data
);

   logic                  res_valid;
   logic                  res_ready;
   icymd_pkg::result_type res_item;
   icymd_pkg::result_type rsp_item;

   assign csr_ready = 1'b1;

   icymd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_byte   (req_tdata),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_item   (res_item)
   );

   icymd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (res_valid),
      .load_ready (res_ready),
      .load_item  (res_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = rsp_item.data;
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.block_end;

endmodule

// ===== hw/rtl/icymd_out.sv =====
// Result register of the ICY metadata demultiplexer.
// Depends on icymd_pkg for the result item type.

module icymd_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   output logic                 load_ready,
   input  icymd_pkg::result_type load_item,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output icymd_pkg::result_type rsp_item
);

   logic                  valid_ff, valid_in;
   icymd_pkg::result_type item_ff, item_in;

   // The register may be refilled in the same cycle that its item is taken.
   assign load_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
         item_in  = load_item;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

// ===== hw/rtl/icymd_core.sv =====
// Input register, interval register and phase/counter logic of the demultiplexer.
// Depends on icymd_pkg; hands result items to icymd_out.

module icymd_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [icymd_pkg::INTERVAL_W-1:0] csr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_op,
   input  logic [icymd_pkg::BYTE_W-1:0]     req_byte,
   output logic                             res_valid,
   input  logic                             res_ready,
   output icymd_pkg::result_type            res_item
);

   logic [icymd_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic                             hold_valid_ff, hold_valid_in;
   icymd_pkg::op_type                hold_op_ff, hold_op_in;
   logic [icymd_pkg::BYTE_W-1:0]     hold_byte_ff, hold_byte_in;
   icymd_pkg::phase_type             phase_ff, phase_in;
   logic [icymd_pkg::INTERVAL_W-1:0] audio_count_ff, audio_count_in;
   logic [icymd_pkg::META_W-1:0]     meta_left_ff, meta_left_in;

   logic                             emits;
   logic                             advance;
   logic [icymd_pkg::INTERVAL_W-1:0] count_next;
   logic [icymd_pkg::META_W-1:0]     meta_len;

   assign count_next = audio_count_ff + icymd_pkg::INTERVAL_W'(1);
   assign meta_len   = {hold_byte_ff, icymd_pkg::UNIT_SHIFT'(0)};

   always_comb begin
      emits           = 1'b0;
      res_item        = '{kind: icymd_pkg::KIND_AUDIO, data: hold_byte_ff, block_end: 1'b0};
      phase_in        = phase_ff;
      audio_count_in  = audio_count_ff;
      meta_left_in    = meta_left_ff;
      if (hold_op_ff == icymd_pkg::OP_RESTART) begin
         phase_in       = icymd_pkg::PH_AUDIO;
         audio_count_in = '0;
         meta_left_in   = '0;
      end else begin
         unique case (phase_ff)
            icymd_pkg::PH_LENGTH: begin
               meta_left_in = meta_len;
               if (meta_len == '0) begin
                  phase_in       = icymd_pkg::PH_AUDIO;
                  audio_count_in = '0;
               end else begin
                  phase_in = icymd_pkg::PH_META;
               end
            end
            icymd_pkg::PH_META: begin
               emits              = 1'b1;
               res_item.kind      = icymd_pkg::KIND_META;
               res_item.block_end = (meta_left_ff <= icymd_pkg::META_W'(1));
               if (res_item.block_end) begin
                  meta_left_in   = '0;
                  phase_in       = icymd_pkg::PH_AUDIO;
                  audio_count_in = '0;
               end else begin
                  meta_left_in = meta_left_ff - icymd_pkg::META_W'(1);
               end
            end
            default: begin
               // The unused phase code behaves as audio.
               emits    = 1'b1;
               phase_in = icymd_pkg::PH_AUDIO;
               if (interval_ff != '0) begin
                  if (count_next == '0 || count_next >= interval_ff) begin
                     audio_count_in = '0;
                     phase_in       = icymd_pkg::PH_LENGTH;
                  end else begin
                     audio_count_in = count_next;
                  end
               end
            end
         endcase
      end
   end

   // An item without a result leaves the input register at once.
   assign advance    = hold_valid_ff && (!emits || res_ready);
   assign res_valid  = hold_valid_ff && emits;
   assign req_tready = !hold_valid_ff || advance;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_op_in    = hold_op_ff;
      hold_byte_in  = hold_byte_ff;
      if (req_tvalid && req_tready) begin
         hold_valid_in = 1'b1;
         hold_op_in    = icymd_pkg::op_type'(req_op);
         hold_byte_in  = req_byte;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end
      interval_in = csr_valid ? csr_data : interval_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff    <= '0;
         hold_valid_ff  <= 1'b0;
         phase_ff       <= icymd_pkg::PH_AUDIO;
         audio_count_ff <= '0;
         meta_left_ff   <= '0;
      end else begin
         interval_ff   <= interval_in;
         hold_valid_ff <= hold_valid_in;
         if (advance) begin
            phase_ff       <= phase_in;
            audio_count_ff <= audio_count_in;
            meta_left_ff   <= meta_left_in;
         end
      end
      hold_op_ff   <= hold_op_in;
      hold_byte_ff <= hold_byte_in;
   end

   // Metadata bytes are outstanding exactly while in the metadata phase.
   a_meta_left_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == icymd_pkg::PH_META) == (meta_left_ff != '0))
      else $error("meta_left disagrees with phase");

   // Audio bytes are only counted during the audio phase.
   a_count_phase: assert property (@(posedge clock) disable iff (reset)
      (audio_count_ff != '0) |-> (phase_ff == icymd_pkg::PH_AUDIO))
      else $error("audio count held outside the audio phase");

   // A restart that leaves the input register returns to the start of audio.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && hold_op_ff == icymd_pkg::OP_RESTART) |=>
      (phase_ff == icymd_pkg::PH_AUDIO && audio_count_ff == '0 && meta_left_ff == '0))
      else $error("restart did not clear the state");

   // A length byte never produces a result item.
   a_length_silent: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && hold_op_ff == icymd_pkg::OP_BYTE && phase_ff == icymd_pkg::PH_LENGTH)
      |-> !res_valid)
      else $error("length byte produced a result");

endmodule
